// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, quiet while reset is held.
`define QP3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked implication, quiet while reset is held.
`define QP3_IMPLY(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

`endif

// ===== src/qp3_pkg.sv =====
package qp3_pkg;

  localparam int MAX_DIM     = 64;
  localparam int GHOST       = 2;
  localparam int PAD_DIM     = MAX_DIM + 2 * GHOST;
  localparam int PLANE_WORDS = PAD_DIM * PAD_DIM;
  localparam int PADDR_W     = $clog2(PLANE_WORDS);
  localparam int POS_W       = $clog2(PAD_DIM);
  localparam int CRD_W       = $clog2(MAX_DIM);
  localparam int TAPS        = 5;
  localparam int HIST        = TAPS - 1;
  localparam int CHILDREN    = 8;
  localparam int CHILD_W     = $clog2(CHILDREN);

  localparam int DIM_W = 7;
  localparam int SW    = 32;
  localparam int ZW    = SW + 8;
  localparam int YW    = ZW + 8;
  localparam int XSW   = YW + 8;
  localparam int FW    = 7;
  localparam int RSHIFT = 21;

  localparam int PLANE_DW = HIST * SW;
  localparam int ROW_DW   = HIST * 2 * ZW;

  typedef enum logic [1:0] {
    CFG_DIM_X = 2'd0,
    CFG_DIM_Y = 2'd1,
    CFG_DIM_Z = 2'd2
  } cfg_idx_e;

  // y-filtered values of one x column, index {py, pz}
  typedef logic [3:0][YW-1:0] yset_t;

  function automatic logic [POS_W-1:0] pad_dim(input logic [DIM_W-1:0] raw);
    logic [POS_W-1:0] r;
    if (raw == '0) begin
      r = POS_W'(1 + 2 * GHOST);
    end else if (int'(raw) > MAX_DIM) begin
      r = POS_W'(PAD_DIM);
    end else begin
      r = POS_W'(raw) + POS_W'(2 * GHOST);
    end
    return r;
  endfunction

  // Five-tap quartic weighting; even (-3,22,128,-22,3), odd is the mirror.
  function automatic logic signed [XSW-1:0] wsum(
    input logic odd,
    input logic signed [XSW-1:0] a0,
    input logic signed [XSW-1:0] a1,
    input logic signed [XSW-1:0] a2,
    input logic signed [XSW-1:0] a3,
    input logic signed [XSW-1:0] a4
  );
    logic signed [XSW-1:0] c;
    logic signed [XSW-1:0] p;
    logic signed [XSW-1:0] q;
    logic signed [XSW-1:0] d;
    c = a2 <<< 7;
    p = a4 - a0;
    q = a1 - a3;
    d = (p <<< 1) + p + (q <<< 4) + (q <<< 2) + (q <<< 1);
    return odd ? (c - d) : (c + d);
  endfunction

  // Round half up after dividing by 2^21, then clamp to 32 bits.
  function automatic logic signed [SW-1:0] round_sat(input logic signed [XSW-1:0] t);
    logic signed [XSW-1:0] s;
    logic signed [XSW-1:0] hi;
    logic signed [XSW-1:0] lo;
    logic signed [SW-1:0] r;
    s  = (t + (XSW'(1) <<< (RSHIFT - 1))) >>> RSHIFT;
    hi = XSW'({1'b0, {(SW-1){1'b1}}});
    lo = -hi - XSW'(1);
    if (s > hi) begin
      r = {1'b0, {(SW-1){1'b1}}};
    end else if (s < lo) begin
      r = {1'b1, {(SW-1){1'b0}}};
    end else begin
      r = s[SW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/qp3_ram.sv =====
module qp3_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/qp3_cell.sv =====
// One x tap: holds the y-filtered column and passes it on each beat.
module qp3_cell import qp3_pkg::*; (
  input  logic  clk_i,
  input  logic  shift_i,
  input  yset_t col_i,
  output yset_t col_o
);

  yset_t col_q;
  yset_t col_d;

  assign col_d = shift_i ? col_i : col_q;

  always_ff @(posedge clk_i) begin
    col_q <= col_d;
  end

  assign col_o = col_q;

endmodule

// ===== src/quartic_prolongation_3d_top.sv =====
// Channel   Dir  Handshake               Payload
// -------   ---  ----------------------  -----------------------------------------
// coarse    in   in_valid_i/in_stall_o   coarse_sample_i
// fine      out  out_valid_o/out_stall_i fine_value_o fine_x_o fine_y_o fine_z_o
//                                        last_child_o
// config    in   cfg_we_i                cfg_idx_i cfg_data_i
//
// An interior coarse beat yields eight fine beats, one per cycle while the fine
// port is not stalled; ghost beats go at one per cycle. The limit is the fine
// port: one beat per cycle out of the burst register. An interior accept passes
// stages 1 to 3, the pending slot, the burst register and the output register.
// Reset clears positions and all valid flags and sets dims to 8 each; store
// contents are left alone. An interior coarse beat waits while an earlier one is
// still in the three filter stages or the pending slot. A stall on the fine port
// holds the output register, so a second burst waits in the pending slot.
module quartic_prolongation_3d_top import qp3_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [SW-1:0]  coarse_sample_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [SW-1:0]  fine_value_o,
  output logic [FW-1:0]         fine_x_o,
  output logic [FW-1:0]         fine_y_o,
  output logic [FW-1:0]         fine_z_o,
  output logic                  last_child_o,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [DIM_W-1:0]      cfg_data_i
);

`include "assert_macros.svh"

  // ---------------- configuration and raster position ----------------
  logic [DIM_W-1:0] dim_x_q, dim_y_q, dim_z_q;
  logic [POS_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [POS_W-1:0] ex, ey, ez;
  logic             in_acc;
  logic             in_int;
  logic             busy;

  assign ex = pad_dim(dim_x_q);
  assign ey = pad_dim(dim_y_q);
  assign ez = pad_dim(dim_z_q);

  // interior once all five taps on every axis are in
  assign in_int = (pos_x_q >= POS_W'(HIST)) && (pos_y_q >= POS_W'(HIST)) &&
                  (pos_z_q >= POS_W'(HIST));
  assign in_stall_o = in_int && busy;
  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q <= DIM_W'(8);
      dim_y_q <= DIM_W'(8);
      dim_z_q <= DIM_W'(8);
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DIM_X: begin
          dim_x_q <= cfg_data_i;
          pos_x_q <= '0; pos_y_q <= '0; pos_z_q <= '0;
        end
        CFG_DIM_Y: begin
          dim_y_q <= cfg_data_i;
          pos_x_q <= '0; pos_y_q <= '0; pos_z_q <= '0;
        end
        CFG_DIM_Z: begin
          dim_z_q <= cfg_data_i;
          pos_x_q <= '0; pos_y_q <= '0; pos_z_q <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      if (pos_x_q == ex - POS_W'(1)) begin
        pos_x_q <= '0;
        if (pos_y_q == ey - POS_W'(1)) begin
          pos_y_q <= '0;
          pos_z_q <= (pos_z_q == ez - POS_W'(1)) ? '0 : pos_z_q + POS_W'(1);
        end else begin
          pos_y_q <= pos_y_q + POS_W'(1);
        end
      end else begin
        pos_x_q <= pos_x_q + POS_W'(1);
      end
    end
  end

  // ---------------- stage 1: plane history read, z filter ----------------
  logic [PADDR_W-1:0]   in_paddr;
  logic [PLANE_DW-1:0]  pl_rdata;
  logic                 s1_v_q, s1_int_q;
  logic signed [SW-1:0] s1_sample_q;
  logic [PADDR_W-1:0]   s1_paddr_q;
  logic [POS_W-1:0]     s1_x_q;
  logic [CRD_W-1:0]     s1_cx_q, s1_cy_q, s1_cz_q;
  logic signed [ZW-1:0] zf [2];

  assign in_paddr = PADDR_W'(pos_y_q) * PADDR_W'(PAD_DIM) + PADDR_W'(pos_x_q);

  // lane 0 holds plane z-1, lane 3 plane z-4
  qp3_ram #(.W(PLANE_DW), .D(PLANE_WORDS)) u_plane_ram (
    .clk_i   (clk_i),
    .we_i    (s1_v_q),
    .waddr_i (s1_paddr_q),
    .wdata_i ({pl_rdata[PLANE_DW-SW-1:0], s1_sample_q}),
    .re_i    (in_acc),
    .raddr_i (in_paddr),
    .rdata_o (pl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s1_int_q <= 1'b0;
    end else begin
      s1_v_q   <= in_acc;
      s1_int_q <= in_acc && in_int;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= coarse_sample_i;
      s1_paddr_q  <= in_paddr;
      s1_x_q      <= pos_x_q;
      s1_cx_q     <= CRD_W'(pos_x_q - POS_W'(HIST));
      s1_cy_q     <= CRD_W'(pos_y_q - POS_W'(HIST));
      s1_cz_q     <= CRD_W'(pos_z_q - POS_W'(HIST));
    end
  end

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      zf[p] = ZW'(wsum(p[0],
        XSW'($signed(pl_rdata[3*SW +: SW])),
        XSW'($signed(pl_rdata[2*SW +: SW])),
        XSW'($signed(pl_rdata[1*SW +: SW])),
        XSW'($signed(pl_rdata[0*SW +: SW])),
        XSW'(s1_sample_q)));
    end
  end

  // ---------------- stage 2: row history read, y filter ----------------
  logic                 s2_v_q, s2_int_q;
  logic signed [ZW-1:0] s2_zf_q [2];
  logic [POS_W-1:0]     s2_x_q;
  logic [CRD_W-1:0]     s2_cx_q, s2_cy_q, s2_cz_q;
  logic [ROW_DW-1:0]    row_rdata;
  yset_t                yf;

  // lanes {row k, pz}: row 0 is y-1, row 3 is y-4
  qp3_ram #(.W(ROW_DW), .D(PAD_DIM)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (s2_v_q),
    .waddr_i (s2_x_q),
    .wdata_i ({row_rdata[ROW_DW-2*ZW-1:0], s2_zf_q[1], s2_zf_q[0]}),
    .re_i    (s1_v_q),
    .raddr_i (s1_x_q),
    .rdata_o (row_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q   <= 1'b0;
      s2_int_q <= 1'b0;
    end else begin
      s2_v_q   <= s1_v_q;
      s2_int_q <= s1_int_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      s2_zf_q[0] <= zf[0];
      s2_zf_q[1] <= zf[1];
      s2_x_q     <= s1_x_q;
      s2_cx_q    <= s1_cx_q;
      s2_cy_q    <= s1_cy_q;
      s2_cz_q    <= s1_cz_q;
    end
  end

  always_comb begin
    for (int py = 0; py < 2; py++) begin
      for (int pz = 0; pz < 2; pz++) begin
        yf[py*2+pz] = YW'(wsum(py[0],
          XSW'($signed(row_rdata[(3*2+pz)*ZW +: ZW])),
          XSW'($signed(row_rdata[(2*2+pz)*ZW +: ZW])),
          XSW'($signed(row_rdata[(1*2+pz)*ZW +: ZW])),
          XSW'($signed(row_rdata[(0*2+pz)*ZW +: ZW])),
          XSW'(s2_zf_q[pz])));
      end
    end
  end

  // ---------------- x tap chain ----------------
  yset_t col [TAPS+1];
  assign col[0] = yf;

  for (genvar g = 0; g < TAPS; g++) begin : g_tap
    qp3_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (s2_v_q),
      .col_i   (col[g]),
      .col_o   (col[g+1])
    );
  end

  // ---------------- stage 3: x filter into pending burst ----------------
  logic                  s3_int_q;
  logic [CRD_W-1:0]      s3_cx_q, s3_cy_q, s3_cz_q;
  logic signed [XSW-1:0] xs [CHILDREN];
  logic                  pend_v_q;
  logic signed [XSW-1:0] pend_q [CHILDREN];
  logic [CRD_W-1:0]      pend_cx_q, pend_cy_q, pend_cz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_int_q <= 1'b0;
    end else begin
      s3_int_q <= s2_int_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      s3_cx_q <= s2_cx_q;
      s3_cy_q <= s2_cy_q;
      s3_cz_q <= s2_cz_q;
    end
  end

  // col[1] is the newest column (offset +2), col[5] the oldest;
  // child bits are {pz, py, px}, column sets are indexed {py, pz}
  always_comb begin
    for (int c = 0; c < CHILDREN; c++) begin
      xs[c] = wsum(c[0],
        XSW'($signed(col[5][{c[1], c[2]}])),
        XSW'($signed(col[4][{c[1], c[2]}])),
        XSW'($signed(col[3][{c[1], c[2]}])),
        XSW'($signed(col[2][{c[1], c[2]}])),
        XSW'($signed(col[1][{c[1], c[2]}])));
    end
  end

  // ---------------- burst register and output ----------------
  logic                  burst_v_q;
  logic [CHILD_W-1:0]    burst_cnt_q;
  logic signed [XSW-1:0] burst_q [CHILDREN];
  logic [CRD_W-1:0]      burst_cx_q, burst_cy_q, burst_cz_q;
  logic                  out_load;
  logic                  burst_end;
  logic                  burst_take;
  logic                  out_v_q;

  assign out_load   = burst_v_q && (!out_v_q || !out_stall_i);
  assign burst_end  = out_load && (burst_cnt_q == CHILD_W'(CHILDREN - 1));
  assign burst_take = pend_v_q && (!burst_v_q || burst_end);
  assign busy       = s1_int_q || s2_int_q || s3_int_q || pend_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q    <= 1'b0;
      burst_v_q   <= 1'b0;
      burst_cnt_q <= '0;
      out_v_q     <= 1'b0;
    end else begin
      if (s3_int_q) begin
        pend_v_q <= 1'b1;
      end else if (burst_take) begin
        pend_v_q <= 1'b0;
      end
      if (burst_take) begin
        burst_v_q <= 1'b1;
      end else if (burst_end) begin
        burst_v_q <= 1'b0;
      end
      if (burst_take) begin
        burst_cnt_q <= '0;
      end else if (out_load) begin
        burst_cnt_q <= burst_cnt_q + CHILD_W'(1);
      end
      if (out_load) begin
        out_v_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_int_q) begin
      pend_q    <= xs;
      pend_cx_q <= s3_cx_q;
      pend_cy_q <= s3_cy_q;
      pend_cz_q <= s3_cz_q;
    end
    if (burst_take) begin
      burst_q    <= pend_q;
      burst_cx_q <= pend_cx_q;
      burst_cy_q <= pend_cy_q;
      burst_cz_q <= pend_cz_q;
    end
    if (out_load) begin
      fine_value_o <= round_sat(burst_q[burst_cnt_q]);
      fine_x_o     <= FW'({burst_cx_q, burst_cnt_q[0]});
      fine_y_o     <= FW'({burst_cy_q, burst_cnt_q[1]});
      fine_z_o     <= FW'({burst_cz_q, burst_cnt_q[2]});
      last_child_o <= (burst_cnt_q == CHILD_W'(CHILDREN - 1));
    end
  end

  assign out_valid_o = out_v_q;

  // ---------------- assertions ----------------
  `QP3_ASSERT(a_one_interior, $countones({s1_int_q, s2_int_q, s3_int_q, pend_v_q}) <= 1,
    "more than one interior beat in flight")
  `QP3_IMPLY(a_pend_stalls, pend_v_q && in_int, in_stall_o,
    "interior beat taken while a burst is pending")
  `QP3_IMPLY(a_last_odd, out_valid_o && last_child_o,
    fine_x_o[0] && fine_y_o[0] && fine_z_o[0], "last child is not the all-odd child")
  `QP3_IMPLY(a_burst_follows, s3_int_q, ##1 pend_v_q,
    "x filter result not captured")

endmodule
